// ----- hw/rtl/mcem_pkg.sv -----
// ----------------------------------------------------------------------------
// mcem_pkg
// Types, codes and constants shared by the cable error monitor modules.
// ----------------------------------------------------------------------------
package mcem_pkg;

  localparam int NUM_CABLES_DEF    = 4;
  localparam int COUNTER_WIDTH_DEF = 32;

  localparam int NCNT        = 7;
  localparam int TIMER_W     = 16;
  localparam int CABLE_W     = 2;
  localparam int CABLE_CMP_W = 5;
  localparam int MASK_W      = 4;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 16;
  localparam int POS_W       = 16;
  localparam int PROD_W      = 20;
  localparam int RATIO_NUM   = 9;
  localparam int RATIO_DEN   = 10;

  localparam logic [TIMER_W-1:0] TIMER_MAX       = 16'hFFFF;
  localparam logic [TIMER_W-1:0] SYSEX_LIMIT_RST = 16'd1000;
  localparam logic [TIMER_W-1:0] IDLE_LIMIT_RST  = 16'd100;
  localparam logic               AUTO_REC_RST    = 1'b1;

  localparam logic [2:0] CNT_TOTAL = 3'd0;
  localparam logic [2:0] CNT_OVF   = 3'd1;
  localparam logic [2:0] CNT_INC   = 3'd2;
  localparam logic [2:0] CNT_CIN   = 3'd3;
  localparam logic [2:0] CNT_MAL   = 3'd4;
  localparam logic [2:0] CNT_BUSY  = 3'd5;
  localparam logic [2:0] CNT_REC   = 3'd6;

  localparam logic [2:0] ERR_NONE       = 3'd0;
  localparam logic [2:0] ERR_OVERFLOW   = 3'd1;
  localparam logic [2:0] ERR_INCOMPLETE = 3'd2;
  localparam logic [2:0] ERR_BAD_CIN    = 3'd3;
  localparam logic [2:0] ERR_BAD_CABLE  = 3'd4;
  localparam logic [2:0] ERR_BUSY       = 3'd5;
  localparam logic [2:0] ERR_MALFORMED  = 3'd6;
  localparam logic [2:0] ERR_TIMEOUT    = 3'd7;

  localparam logic [1:0] CS_OK    = 2'd0;
  localparam logic [1:0] CS_ERROR = 2'd1;
  localparam logic [1:0] CS_WARN  = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_SYSEX_LIMIT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IDLE_LIMIT  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_AUTO_REC    = 2'd2;

  typedef enum logic [3:0] {
    OP_TICK        = 4'd0,
    OP_ACTIVITY    = 4'd1,
    OP_SYSEX_START = 4'd2,
    OP_SYSEX_END   = 4'd3,
    OP_REPORT      = 4'd4,
    OP_OVF_CHECK   = 4'd5,
    OP_RECOVER     = 4'd6,
    OP_CLEAR       = 4'd7,
    OP_READ        = 4'd8
  } op_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_MODIFY,
    ST_DONE
  } mcem_state_t;

  typedef struct packed {
    logic [TIMER_W-1:0] idle_timer;
    logic [TIMER_W-1:0] sysex_timer;
    logic               sysex_open;
    logic [1:0]         link_state;
    logic [2:0]         last_code;
  } mcem_meta_t;

  typedef struct packed {
    op_t              op;
    logic [2:0]       error_code;
    logic [POS_W-1:0] buffer_position;
    logic [POS_W-1:0] buffer_capacity;
  } mcem_req_t;

  typedef struct packed {
    logic [TIMER_W-1:0] sysex_timeout_limit;
    logic [TIMER_W-1:0] idle_limit;
    logic               auto_recover_enable;
  } mcem_cfg_t;

endpackage

// ----- hw/rtl/mcem_update.sv -----
// ----------------------------------------------------------------------------
// mcem_update
// Next value of one cable entry for one event: timers, state and counters.
// ----------------------------------------------------------------------------
module mcem_update import mcem_pkg::*; #(
  parameter int COUNTER_WIDTH = COUNTER_WIDTH_DEF
) (
  input  mcem_req_t                             req,
  input  mcem_cfg_t                             cfg,
  input  mcem_meta_t                            meta_in,
  input  logic [NCNT-1:0][COUNTER_WIDTH-1:0]    cnt_in,
  output mcem_meta_t                            meta_out,
  output logic [NCNT-1:0][COUNTER_WIDTH-1:0]    cnt_out,
  output logic                                  timed_out,
  output logic                                  ovf_flag
);

  function automatic logic [TIMER_W-1:0] sat_inc(input logic [TIMER_W-1:0] v);
    return (v != TIMER_MAX) ? v + TIMER_W'(1) : v;
  endfunction

  logic [PROD_W-1:0] pos_x10;
  logic [PROD_W-1:0] cap_x9;

  assign pos_x10 = PROD_W'(req.buffer_position) * PROD_W'(RATIO_DEN);
  assign cap_x9  = PROD_W'(req.buffer_capacity) * PROD_W'(RATIO_NUM);

  always_comb begin
    mcem_meta_t                          m;
    logic [NCNT-1:0][COUNTER_WIDTH-1:0]  cv;
    logic                                rep;
    logic [2:0]                          rep_code;
    logic                                rcv;
    logic                                to;
    logic                                flag;
    logic [2:0]                          kidx;
    logic                                kval;

    m        = meta_in;
    cv       = cnt_in;
    rep      = 1'b0;
    rep_code = ERR_NONE;
    rcv      = 1'b0;
    to       = 1'b0;
    flag     = 1'b0;
    kidx     = CNT_TOTAL;
    kval     = 1'b0;

    unique case (req.op)
      OP_TICK: begin
        m.idle_timer = sat_inc(m.idle_timer);
        if (m.sysex_open) begin
          m.sysex_timer = sat_inc(m.sysex_timer);
          if (m.sysex_timer > cfg.sysex_timeout_limit) begin
            to       = 1'b1;
            rep      = 1'b1;
            rep_code = ERR_INCOMPLETE;
          end
        end
      end
      OP_ACTIVITY: begin
        m.idle_timer = '0;
        if (m.link_state == CS_ERROR) begin
          m.link_state = CS_WARN;
        end
      end
      OP_SYSEX_START: begin
        m.sysex_open  = 1'b1;
        m.sysex_timer = '0;
      end
      OP_SYSEX_END: begin
        m.sysex_open  = 1'b0;
        m.sysex_timer = '0;
      end
      OP_REPORT: begin
        rep      = 1'b1;
        rep_code = req.error_code;
      end
      OP_OVF_CHECK: begin
        if (req.buffer_position >= req.buffer_capacity) begin
          rep      = 1'b1;
          rep_code = ERR_OVERFLOW;
          flag     = 1'b1;
        end else if (pos_x10 > cap_x9) begin
          m.link_state = CS_WARN;
        end
      end
      OP_RECOVER: begin
        rcv = 1'b1;
      end
      OP_CLEAR: begin
        m  = '0;
        cv = '0;
      end
      default: begin
      end
    endcase

    if (rep) begin
      unique case (rep_code)
        ERR_OVERFLOW: begin
          kidx = CNT_OVF;
          kval = 1'b1;
        end
        ERR_INCOMPLETE: begin
          kidx = CNT_INC;
          kval = 1'b1;
        end
        ERR_BAD_CIN: begin
          kidx = CNT_CIN;
          kval = 1'b1;
        end
        ERR_BUSY: begin
          kidx = CNT_BUSY;
          kval = 1'b1;
        end
        ERR_MALFORMED: begin
          kidx = CNT_MAL;
          kval = 1'b1;
        end
        default: begin
        end
      endcase
      if (kval) begin
        cv[kidx] = cv[kidx] + COUNTER_WIDTH'(1);
      end
      cv[CNT_TOTAL] = cv[CNT_TOTAL] + COUNTER_WIDTH'(1);
      m.last_code   = rep_code;
      m.link_state  = CS_ERROR;
      if (cfg.auto_recover_enable) begin
        rcv = 1'b1;
      end
    end

    if (rcv) begin
      m.sysex_open  = 1'b0;
      m.sysex_timer = '0;
      m.idle_timer  = '0;
      m.link_state  = CS_OK;
      cv[CNT_REC]   = cv[CNT_REC] + COUNTER_WIDTH'(1);
    end

    if (to) begin
      m.sysex_open  = 1'b0;
      m.sysex_timer = '0;
    end

    if (req.op == OP_TICK && m.idle_timer > cfg.idle_limit && m.link_state == CS_WARN) begin
      m.link_state = CS_OK;
    end

    meta_out  = m;
    cnt_out   = cv;
    timed_out = to;
    ovf_flag  = flag;
  end

endmodule

// ----- hw/rtl/midi_cable_error_monitor.sv -----
// ----------------------------------------------------------------------------
// midi_cable_error_monitor
// Per-cable error monitor: timers, state and error counters for each cable,
// kept in an entry memory and updated by read, modify and write back.
//
//   Channel  Direction  Handshake                Payload
//   in       input      in_valid / in_stall      op, cable, all_cables,
//                                                error_code, buffer_position,
//                                                buffer_capacity
//   out      output     out_valid / out_stall    cable_status, counters,
//                                                last_error_code,
//                                                overflow_flag, timeout_mask
//   cfg      input      cfg_write                cfg_index, cfg_data
//
// A tick visits every cable entry in turn, every other event only its own
// cable (none for a cable number out of range); each entry visit is a memory
// read step and then a modify and write-back step on the single entry memory.
// Reset marks every entry invalid at once, and an invalid entry reads as zero,
// so there is no clearing pass. One finished result waits in the output
// register; while it is stalled, the next result holds in its last step.
// ----------------------------------------------------------------------------
module midi_cable_error_monitor import mcem_pkg::*; #(
  parameter int NUM_CABLES    = NUM_CABLES_DEF,
  parameter int COUNTER_WIDTH = COUNTER_WIDTH_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_write,
  input  logic [CFG_IDX_W-1:0]     cfg_index,
  input  logic [CFG_DATA_W-1:0]    cfg_data,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [3:0]               op,
  input  logic [CABLE_W-1:0]       cable,
  input  logic                     all_cables,
  input  logic [2:0]               error_code,
  input  logic [POS_W-1:0]         buffer_position,
  input  logic [POS_W-1:0]         buffer_capacity,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic [1:0]               cable_status,
  output logic [COUNTER_WIDTH-1:0] error_total,
  output logic [COUNTER_WIDTH-1:0] overflow_count,
  output logic [COUNTER_WIDTH-1:0] incomplete_count,
  output logic [COUNTER_WIDTH-1:0] bad_cin_count,
  output logic [COUNTER_WIDTH-1:0] malformed_count,
  output logic [COUNTER_WIDTH-1:0] busy_count,
  output logic [COUNTER_WIDTH-1:0] recovery_count,
  output logic [2:0]               last_error_code,
  output logic                     overflow_flag,
  output logic [MASK_W-1:0]        timeout_mask
);

  localparam int CIDX_W = (NUM_CABLES > 1) ? $clog2(NUM_CABLES) : 1;
  localparam logic [CIDX_W-1:0] LAST_IDX = CIDX_W'(NUM_CABLES - 1);

  typedef logic [NCNT-1:0][COUNTER_WIDTH-1:0] cnt_vec_t;

  mcem_cfg_t   cfg;
  mcem_state_t state;
  mcem_state_t state_next;

  mcem_req_t          req;
  logic [CIDX_W-1:0]  cab_addr;
  logic               cab_ok;
  logic [CIDX_W-1:0]  idx;
  logic               in_xfer;
  logic               in_cab_ok;
  logic               out_free;
  logic               is_tick;

  mcem_meta_t         meta_mem [NUM_CABLES];
  cnt_vec_t           cnt_mem  [NUM_CABLES];
  logic [NUM_CABLES-1:0] vld;

  mcem_meta_t         rd_meta;
  cnt_vec_t           rd_cnt;
  logic               rd_ok;
  mcem_meta_t         eff_meta;
  cnt_vec_t           eff_cnt;

  mcem_meta_t         upd_meta;
  cnt_vec_t           upd_cnt;
  logic               upd_to;
  logic               upd_flag;

  mcem_meta_t         res_meta;
  cnt_vec_t           res_cnt;
  logic               res_flag;
  logic [MASK_W-1:0]  res_mask;

  mcem_meta_t         out_meta;
  cnt_vec_t           out_cnt;
  logic               out_flag;
  logic [MASK_W-1:0]  out_mask;

  assign in_xfer   = in_valid && !in_stall;
  assign in_cab_ok = CABLE_CMP_W'(cable) < CABLE_CMP_W'(NUM_CABLES);
  assign out_free  = !out_valid || !out_stall;
  assign is_tick   = (req.op == OP_TICK);
  assign in_stall  = (state != ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.sysex_timeout_limit <= SYSEX_LIMIT_RST;
      cfg.idle_limit          <= IDLE_LIMIT_RST;
      cfg.auto_recover_enable <= AUTO_REC_RST;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_SYSEX_LIMIT: cfg.sysex_timeout_limit <= cfg_data;
        REG_IDLE_LIMIT:  cfg.idle_limit          <= cfg_data;
        REG_AUTO_REC:    cfg.auto_recover_enable <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_xfer) begin
          if (op == OP_TICK || in_cab_ok) begin
            state_next = ST_READ;
          end else begin
            state_next = ST_DONE;
          end
        end
      end
      ST_READ: begin
        state_next = ST_MODIFY;
      end
      ST_MODIFY: begin
        if (is_tick && idx != LAST_IDX) begin
          state_next = ST_READ;
        end else begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      req.op              <= op_t'(op);
      req.error_code      <= error_code;
      req.buffer_position <= buffer_position;
      req.buffer_capacity <= buffer_capacity;
      cab_addr            <= CIDX_W'(cable);
      cab_ok              <= in_cab_ok;
      idx                 <= (op == OP_TICK) ? '0 : CIDX_W'(cable);
    end else if (state == ST_MODIFY && is_tick && idx != LAST_IDX) begin
      idx <= idx + CIDX_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (in_xfer && op == OP_CLEAR && all_cables) begin
      vld <= '0;
    end else if (state == ST_MODIFY) begin
      vld[idx] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_MODIFY) begin
      meta_mem[idx] <= upd_meta;
      cnt_mem[idx]  <= upd_cnt;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_READ) begin
      rd_meta <= meta_mem[idx];
      rd_cnt  <= cnt_mem[idx];
      rd_ok   <= vld[idx];
    end
  end

  assign eff_meta = rd_ok ? rd_meta : '0;
  assign eff_cnt  = rd_ok ? rd_cnt : '0;

  mcem_update #(
    .COUNTER_WIDTH(COUNTER_WIDTH)
  ) u_update (
    .req      (req),
    .cfg      (cfg),
    .meta_in  (eff_meta),
    .cnt_in   (eff_cnt),
    .meta_out (upd_meta),
    .cnt_out  (upd_cnt),
    .timed_out(upd_to),
    .ovf_flag (upd_flag)
  );

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      res_meta <= '0;
      res_cnt  <= '0;
      res_flag <= 1'b0;
      res_mask <= '0;
    end else if (state == ST_MODIFY) begin
      if (cab_ok && idx == cab_addr) begin
        res_meta <= upd_meta;
        res_cnt  <= upd_cnt;
        res_flag <= upd_flag;
      end
      if (upd_to && CABLE_CMP_W'(idx) < CABLE_CMP_W'(MASK_W)) begin
        res_mask[CABLE_W'(idx)] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == ST_DONE && out_free) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_DONE && out_free) begin
      out_meta <= res_meta;
      out_cnt  <= res_cnt;
      out_flag <= res_flag;
      out_mask <= res_mask;
    end
  end

  assign cable_status     = out_meta.link_state;
  assign error_total      = out_cnt[CNT_TOTAL];
  assign overflow_count   = out_cnt[CNT_OVF];
  assign incomplete_count = out_cnt[CNT_INC];
  assign bad_cin_count    = out_cnt[CNT_CIN];
  assign malformed_count  = out_cnt[CNT_MAL];
  assign busy_count       = out_cnt[CNT_BUSY];
  assign recovery_count   = out_cnt[CNT_REC];
  assign last_error_code  = out_meta.last_code;
  assign overflow_flag    = out_flag;
  assign timeout_mask     = out_mask;

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    in_xfer |=> in_stall)
    else $error("input transfer taken while an event is in flight");

  a_result_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == ST_DONE))
    else $error("result presented without a finished event");

  a_overflow_code: assert property (@(posedge clk) disable iff (rst)
    (out_valid && overflow_flag) |-> (last_error_code == ERR_OVERFLOW))
    else $error("overflow flag without overflow error code");

endmodule
